// File: hdl/alt_pkg.sv
// ----------------------------------------------------------------------------
// Line tokenizer package
// Shared byte constants, byte classes, token types and the result word.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_COMMA,
    CLS_QUOTE,
    CLS_OTHER,
    CLS_END
  } cls_e;

  typedef enum logic [2:0] {
    TK_WORD,
    TK_COMMA,
    TK_STRING,
    TK_ERROR,
    TK_END
  } tok_e;

  typedef struct packed {
    tok_e        token_type;
    logic [7:0]  text_start;
    logic [8:0]  text_length;
    logic        overflow;
    logic        last;
  } res_t;

endpackage

// File: hdl/alt_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// Holds up to DEPTH words; takes up to two words and gives one word a cycle.
// ----------------------------------------------------------------------------
module alt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_a_i,
  input  logic [WIDTH-1:0]             data_a_i,
  input  logic                         push_b_i,
  input  logic [WIDTH-1:0]             data_b_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             head_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    wr_ptr_d = wr_ptr_q + PtrW'(push_a_i) + PtrW'(push_b_i);
    count_d  = count_q + CntW'(push_a_i) + CntW'(push_b_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= data_b_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// File: hdl/alt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies each incoming byte and tags it with its saturated line offset.
// ----------------------------------------------------------------------------
module alt_front
  import alt_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          kind_i,
  input  logic [7:0]                    char_byte_i,
  output cls_e                          cls_o,
  output logic [$clog2(MAX_LINE+1)-1:0] pos_o,
  output logic                          ovf_o
);

  localparam int PosW = $clog2(MAX_LINE + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf_q, ovf_d;
  logic            at_limit;

  assign at_limit = (pos_q == PosW'(MAX_LINE));

  always_comb begin
    cls_o = CLS_OTHER;
    if (kind_i) begin
      cls_o = CLS_END;
    end else if (char_byte_i == CHAR_COMMA) begin
      cls_o = CLS_COMMA;
    end else if (char_byte_i == CHAR_QUOTE) begin
      cls_o = CLS_QUOTE;
    end else if (char_byte_i == CHAR_SPACE || char_byte_i == CHAR_TAB ||
                 char_byte_i == CHAR_CR || char_byte_i == CHAR_LF) begin
      cls_o = CLS_BLANK;
    end
  end

  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    ovf_o = ovf_q;
    if (kind_i) begin
      pos_d = '0;
      ovf_d = 1'b0;
    end else if (at_limit) begin
      ovf_d = 1'b1;
      ovf_o = 1'b1;
    end else begin
      pos_d = pos_q + PosW'(1);
    end
  end

  assign pos_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (take_i) begin
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// File: hdl/alt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Runs the scan mode machine and emits up to two tokens per classified byte.
// ----------------------------------------------------------------------------
module alt_back
  import alt_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  cls_e                          item_cls_i,
  input  logic [$clog2(MAX_LINE+1)-1:0] item_pos_i,
  input  logic                          item_ovf_i,
  input  logic                          out_room_i,
  output logic                          item_pop_o,
  output logic                          res_push_a_o,
  output res_t                          res_a_o,
  output logic                          res_push_b_o,
  output res_t                          res_b_o
);

  localparam int PosW = $clog2(MAX_LINE + 1);
  localparam int BegW = $clog2(MAX_LINE);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STRING
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [BegW-1:0] begin_q, begin_d;
  logic            go;
  logic [PosW-1:0] begin_ext;
  logic [PosW-1:0] str_from;
  tok_e            type_a, type_b;
  logic [PosW-1:0] start_a, len_a, start_b;
  logic [1:0]      n_res;

  function automatic logic [PosW-1:0] span(input logic [PosW-1:0] from,
                                           input logic [PosW-1:0] to);
    return (to > from) ? to - from : '0;
  endfunction

  function automatic logic [BegW-1:0] clamp(input logic [PosW-1:0] p);
    return (p >= PosW'(MAX_LINE)) ? BegW'(MAX_LINE - 1) : p[BegW-1:0];
  endfunction

  assign go         = item_valid_i && out_room_i;
  assign item_pop_o = go;
  assign begin_ext  = PosW'(begin_q);
  assign str_from   = begin_ext + PosW'(1);

  always_comb begin
    mode_d  = mode_q;
    begin_d = begin_q;
    n_res   = 2'd0;
    type_a  = TK_END;
    start_a = '0;
    len_a   = '0;
    type_b  = TK_END;
    start_b = '0;
    if (item_cls_i == CLS_END) begin
      mode_d  = MODE_IDLE;
      begin_d = '0;
      case (mode_q)
        MODE_WORD: begin
          n_res   = 2'd2;
          type_a  = TK_WORD;
          start_a = begin_ext;
          len_a   = span(begin_ext, item_pos_i);
        end
        MODE_STRING: begin
          n_res   = 2'd2;
          type_a  = TK_ERROR;
          start_a = begin_ext;
          len_a   = span(begin_ext, item_pos_i);
        end
        default: begin
          n_res = 2'd1;
        end
      endcase
    end else begin
      case (mode_q)
        MODE_WORD: begin
          if (item_cls_i == CLS_BLANK || item_cls_i == CLS_COMMA) begin
            mode_d  = MODE_IDLE;
            type_a  = TK_WORD;
            start_a = begin_ext;
            len_a   = span(begin_ext, item_pos_i);
            n_res   = 2'd1;
            if (item_cls_i == CLS_COMMA) begin
              n_res   = 2'd2;
              type_b  = TK_COMMA;
              start_b = PosW'(clamp(item_pos_i));
            end
          end
        end
        MODE_STRING: begin
          if (item_cls_i == CLS_QUOTE) begin
            mode_d  = MODE_IDLE;
            n_res   = 2'd1;
            type_a  = TK_STRING;
            start_a = PosW'(clamp(str_from));
            len_a   = span(str_from, item_pos_i);
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          if (item_cls_i == CLS_COMMA) begin
            n_res   = 2'd1;
            type_a  = TK_COMMA;
            start_a = PosW'(clamp(item_pos_i));
            len_a   = PosW'(1);
          end else if (item_cls_i == CLS_QUOTE) begin
            begin_d = clamp(item_pos_i);
            mode_d  = MODE_STRING;
          end else if (item_cls_i == CLS_OTHER) begin
            begin_d = clamp(item_pos_i);
            mode_d  = MODE_WORD;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_a_o.token_type  = type_a;
    res_a_o.text_start  = 8'(start_a);
    res_a_o.text_length = 9'(len_a);
    res_a_o.overflow    = item_ovf_i;
    res_a_o.last        = (n_res == 2'd1);
    res_b_o.token_type  = type_b;
    res_b_o.text_start  = 8'(start_b);
    res_b_o.text_length = (type_b == TK_COMMA) ? 9'd1 : 9'd0;
    res_b_o.overflow    = item_ovf_i;
    res_b_o.last        = 1'b1;
    res_push_a_o        = go && (n_res != 2'd0);
    res_push_b_o        = go && (n_res == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
    end else if (go) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
    end
  end

endmodule

// File: hdl/assembly_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Assembly line tokenizer
// Splits a source line, fed one byte per word, into word, comma and string
// tokens with start offset and length.
//
// Input is a queue: push_i with kind_i and char_byte_i is taken when full_o
// is low. kind_i high closes the line. Results come out as a queue: while
// empty_o is low the oldest token is on the result ports, and pop_i takes it.
// One input word can be accepted every cycle while full_o is low. A word
// is queued, then its tokens are queued. An input word gives zero, one
// or two tokens; last_o marks the final token of each word, and a line end
// always gives one end token after any flushed word or error token.
// The front end keeps the line offset, a two-entry queue feeds the back end,
// and the back end writes into a four-entry result queue. When the receiver
// stops popping, the result queue fills, the back end halts, and full_o
// rises once the middle queue is full. Reset empties both queues and returns
// the offset and scan mode to the start of a line.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer
  import alt_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic       kind_i,
  input  logic [7:0] char_byte_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [2:0] token_type_o,
  output logic [7:0] text_start_o,
  output logic [8:0] text_length_o,
  output logic       overflow_o,
  output logic       last_o
);

  localparam int PosW     = $clog2(MAX_LINE + 1);
  localparam int ItemW    = $bits(cls_e) + 1 + PosW;
  localparam int MidDepth = 2;
  localparam int OutDepth = 4;
  localparam int ResW     = $bits(res_t);

  logic                           take;
  cls_e                           front_cls;
  logic [PosW-1:0]                front_pos;
  logic                           front_ovf;
  logic [ItemW-1:0]               mid_in, mid_head;
  logic [$clog2(MidDepth+1)-1:0]  mid_count;
  logic                           item_pop;
  cls_e                           item_cls;
  logic [PosW-1:0]                item_pos;
  logic                           item_ovf;
  logic                           out_room;
  logic                           push_a, push_b;
  res_t                           res_a, res_b, res_head;
  logic [ResW-1:0]                out_head;
  logic [$clog2(OutDepth+1)-1:0]  out_count;

  assign full_o = (mid_count == ($clog2(MidDepth+1))'(MidDepth));
  assign take   = push_i && !full_o;

  alt_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .kind_i     (kind_i),
    .char_byte_i(char_byte_i),
    .cls_o      (front_cls),
    .pos_o      (front_pos),
    .ovf_o      (front_ovf)
  );

  assign mid_in = {front_cls, front_ovf, front_pos};

  alt_fifo #(
    .WIDTH(ItemW),
    .DEPTH(MidDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(take),
    .data_a_i(mid_in),
    .push_b_i(1'b0),
    .data_b_i(mid_in),
    .pop_i   (item_pop),
    .head_o  (mid_head),
    .count_o (mid_count)
  );

  assign item_cls = cls_e'(mid_head[ItemW-1 -: $bits(cls_e)]);
  assign item_ovf = mid_head[PosW];
  assign item_pos = mid_head[PosW-1:0];
  assign out_room = (out_count <= ($clog2(OutDepth+1))'(OutDepth - 2));

  alt_back #(
    .MAX_LINE(MAX_LINE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(mid_count != '0),
    .item_cls_i  (item_cls),
    .item_pos_i  (item_pos),
    .item_ovf_i  (item_ovf),
    .out_room_i  (out_room),
    .item_pop_o  (item_pop),
    .res_push_a_o(push_a),
    .res_a_o     (res_a),
    .res_push_b_o(push_b),
    .res_b_o     (res_b)
  );

  alt_fifo #(
    .WIDTH(ResW),
    .DEPTH(OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(push_a),
    .data_a_i(res_a),
    .push_b_i(push_b),
    .data_b_i(res_b),
    .pop_i   (pop_i && !empty_o),
    .head_o  (out_head),
    .count_o (out_count)
  );

  assign res_head      = res_t'(out_head);
  assign empty_o       = (out_count == '0);
  assign token_type_o  = res_head.token_type;
  assign text_start_o  = res_head.text_start;
  assign text_length_o = res_head.text_length;
  assign overflow_o    = res_head.overflow;
  assign last_o        = res_head.last;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && token_type_o == TK_END) |-> last_o)
    else $error("End token without last flag.");

  a_comma_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && token_type_o == TK_COMMA) |-> (text_length_o == 9'd1))
    else $error("Comma token with length other than one.");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && token_type_o == TK_END) |-> (text_start_o == 8'd0 &&
                                              text_length_o == 9'd0))
    else $error("End token with nonzero start or length.");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_b |-> push_a && out_room)
    else $error("Result queue written past its room.");
`endif

endmodule
